// File: design/msq_pkg.sv
// shared widths, limits and the cell flag word for the maximal square block
`timescale 1ns / 1ps

package msq_pkg;

   localparam int CFG_W  = 11;
   localparam int SIDE_W = 11;
   localparam int AREA_W = 21;

   localparam logic [CFG_W-1:0]  ROW_WIDTH_RESET = 11'd1024;
   localparam logic [SIDE_W-1:0] SIDE_MAX        = 11'd2047;
   localparam logic [AREA_W-1:0] AREA_MAX        = 21'd2097151;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic cell_bit;
      logic last_cell;
      logic first_row;
      logic row_end;
   } cell_flags_type;

endpackage

// File: design/msq_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module msq_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/msq_front.sv
// front end: row width register, column tracking and cell classification
`timescale 1ns / 1ps

module msq_front #(
   parameter int MAX_COLS = 1024,
   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [msq_pkg::CFG_W-1:0]   csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cell_bit,
   input  logic                        req_last_cell,
   input  logic                        queue_full,
   output logic                        push,
   output msq_pkg::cell_flags_type     push_flags,
   output logic [COL_W-1:0]            push_col
);

   import msq_pkg::*;

   localparam int XW = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

   logic [CFG_W-1:0] row_width_ff, row_width_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             first_row_ff, first_row_in;

   logic [XW-1:0] width_raw;
   logic [XW-1:0] width_eff;
   logic [XW-1:0] col_plus;
   logic          row_end;

   always_comb begin
      width_raw = XW'(row_width_ff);
      // zero acts as one column, oversize clamps to the line store depth
      if (width_raw == '0) begin
         width_eff = XW'(1);
      end else if (width_raw > XW'(MAX_COLS)) begin
         width_eff = XW'(MAX_COLS);
      end else begin
         width_eff = width_raw;
      end
      col_plus = XW'(col_ff) + XW'(1);
      row_end  = (col_plus >= width_eff);
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !req_stall;

   always_comb begin
      push_flags.cell_bit  = req_cell_bit;
      push_flags.last_cell = req_last_cell;
      push_flags.first_row = first_row_ff;
      push_flags.row_end   = row_end;
      push_col             = col_ff;
   end

   always_comb begin
      row_width_in = csr_wr_en ? csr_wr_data : row_width_ff;
      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (push) begin
         priority if (req_last_cell) begin
            col_in       = '0;
            first_row_in = 1'b1;
         end else if (row_end) begin
            col_in       = '0;
            first_row_in = 1'b0;
         end else begin
            col_in = col_plus[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         col_ff       <= '0;
         first_row_ff <= 1'b1;
      end else begin
         row_width_ff <= row_width_in;
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
      end
   end

endmodule

// File: design/msq_queue.sv
// two-entry queue of classified cells between front and back
`timescale 1ns / 1ps

module msq_queue #(
   parameter int COL_W = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  msq_pkg::cell_flags_type push_flags,
   input  logic [COL_W-1:0]        push_col,
   input  logic                    pop,
   output logic                    full,
   output logic                    not_empty,
   output msq_pkg::cell_flags_type head_flags,
   output logic [COL_W-1:0]        head_col
);

   import msq_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cell_flags_type   flags_ff [QUEUE_DEPTH];
   logic [COL_W-1:0] col_ff   [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty  = (count_ff != '0);
   assign head_flags = flags_ff[rd_ptr_ff];
   assign head_col   = col_ff[rd_ptr_ff];

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      if (p == PW'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         flags_ff[wr_ptr_ff] <= push_flags;
         col_ff[wr_ptr_ff]   <= push_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/msq_back.sv
// back end: line store, side update, running best and result output
`timescale 1ns / 1ps

module msq_back #(
   parameter int MAX_COLS = 1024,
   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  msq_pkg::cell_flags_type      head_flags,
   input  logic [COL_W-1:0]             head_col,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [msq_pkg::AREA_W-1:0]   rsp_max_area,
   output logic [msq_pkg::SIDE_W-1:0]   rsp_max_side
);

   import msq_pkg::*;

   // compute stage
   logic                b_valid_ff, b_valid_in;
   cell_flags_type      b_flags_ff;
   logic [COL_W-1:0]    b_col_ff;
   logic                fwd_ff, fwd_in;
   logic [SIDE_W-1:0]   fwd_side_ff;
   logic [SIDE_W-1:0]   left_ff, left_in;
   logic [SIDE_W-1:0]   diag_ff, diag_in;
   logic [SIDE_W-1:0]   best_ff, best_in;

   // result stages: side, then side and area
   logic                c_valid_ff, c_valid_in;
   logic [SIDE_W-1:0]   c_side_ff;
   logic                d_valid_ff, d_valid_in;
   logic [SIDE_W-1:0]   d_side_ff;
   logic [AREA_W-1:0]   d_area_ff;

   logic [SIDE_W-1:0]   rd_data;
   logic [SIDE_W-1:0]   up;
   logic [SIDE_W-1:0]   min_lu;
   logic [SIDE_W-1:0]   min_all;
   logic [SIDE_W-1:0]   side;
   logic [SIDE_W-1:0]   best_next;
   logic                adv;
   logic                c_adv;
   logic                wr_en;
   logic                b_load_res;
   logic [2*SIDE_W-1:0] area_full;
   logic [AREA_W-1:0]   area_sat;

   msq_ram #(
      .WIDTH (SIDE_W),
      .DEPTH (MAX_COLS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_col_ff),
      .wr_data (side),
      .rd_en   (pop),
      .rd_addr (head_col),
      .rd_data (rd_data)
   );

   always_comb begin
      // up neighbor: zero in the first row, bypass when the same column was just written
      if (b_flags_ff.first_row) begin
         up = '0;
      end else if (fwd_ff) begin
         up = fwd_side_ff;
      end else begin
         up = rd_data;
      end
      min_lu  = (up < left_ff) ? up : left_ff;
      min_all = (min_lu < diag_ff) ? min_lu : diag_ff;
      if (!b_flags_ff.cell_bit) begin
         side = '0;
      end else if (min_all == SIDE_MAX) begin
         side = SIDE_MAX;
      end else begin
         side = min_all + SIDE_W'(1);
      end
      best_next = (side > best_ff) ? side : best_ff;
   end

   assign c_adv = c_valid_ff && (!d_valid_ff || !rsp_stall);
   // only a result word can hold up the compute stage
   assign adv   = !(b_valid_ff && b_flags_ff.last_cell && c_valid_ff && !c_adv);
   assign pop   = head_valid && adv;
   assign wr_en = b_valid_ff && adv;
   assign b_load_res = b_valid_ff && adv && b_flags_ff.last_cell;

   always_comb begin
      b_valid_in = adv ? pop : b_valid_ff;
      fwd_in     = fwd_ff;
      if (adv) begin
         fwd_in = pop && b_valid_ff && (head_col == b_col_ff);
      end
      left_in = left_ff;
      diag_in = diag_ff;
      best_in = best_ff;
      if (wr_en) begin
         priority if (b_flags_ff.last_cell) begin
            left_in = '0;
            diag_in = '0;
            best_in = '0;
         end else if (b_flags_ff.row_end) begin
            left_in = '0;
            diag_in = '0;
            best_in = best_next;
         end else begin
            left_in = side;
            diag_in = up;
            best_in = best_next;
         end
      end
   end

   always_comb begin
      priority if (b_load_res) begin
         c_valid_in = 1'b1;
      end else if (c_adv) begin
         c_valid_in = 1'b0;
      end else begin
         c_valid_in = c_valid_ff;
      end
      priority if (c_adv) begin
         d_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         d_valid_in = 1'b0;
      end else begin
         d_valid_in = d_valid_ff;
      end
      area_full = c_side_ff * c_side_ff;
      if (area_full > (2*SIDE_W)'(AREA_MAX)) begin
         area_sat = AREA_MAX;
      end else begin
         area_sat = area_full[AREA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_flags_ff  <= head_flags;
         b_col_ff    <= head_col;
         fwd_side_ff <= side;
      end
      if (b_load_res) begin
         c_side_ff <= best_next;
      end
      if (c_adv) begin
         d_side_ff <= c_side_ff;
         d_area_ff <= area_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         fwd_ff     <= 1'b0;
         left_ff    <= '0;
         diag_ff    <= '0;
         best_ff    <= '0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         fwd_ff     <= fwd_in;
         left_ff    <= left_in;
         diag_ff    <= diag_in;
         best_ff    <= best_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   assign rsp_valid    = d_valid_ff;
   assign rsp_max_side = d_side_ff;
   assign rsp_max_area = d_area_ff;

   // a first-row cell has no up neighbor, so its side is at most one
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_flags_ff.first_row |-> side <= SIDE_W'(1))
      else $error("first-row side exceeds one");

   // the running best only drops when a matrix ends
   assert property (@(posedge clock) disable iff (reset)
      wr_en && !b_flags_ff.last_cell |=> best_ff >= $past(best_ff))
      else $error("running best decreased inside a matrix");

   // a stalled compute stage never writes the line store or pops the queue
   assert property (@(posedge clock) disable iff (reset)
      !adv |-> !wr_en && !pop && c_valid_ff && d_valid_ff)
      else $error("compute stage moved while held");

endmodule

// File: design/maximal_square_of_ones.sv
// Streams a binary matrix one cell per word in row-major order and reports the
// side and area of the largest all-ones square when the word marked as last cell
// has been processed. It takes one cell every clock cycle while req_stall is low;
// each cell costs one read and one write of the single-port-per-direction line
// store, which holds the previous row's square sides (MAX_COLS entries). The
// result word is held in an output register, so new cells keep flowing while it
// waits, until later last cells fill the result registers. csr_wr_data sets the
// row width (0 acts as 1, values above MAX_COLS act as MAX_COLS) and should only
// be written between words; the line store needs no clearing after reset.
`timescale 1ns / 1ps

module maximal_square_of_ones #(
   parameter int MAX_COLS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [msq_pkg::CFG_W-1:0]    csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cell_bit,
   input  logic                         req_last_cell,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [msq_pkg::AREA_W-1:0]   rsp_max_area,
   output logic [msq_pkg::SIDE_W-1:0]   rsp_max_side
);

   import msq_pkg::*;

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic             push;
   cell_flags_type   push_flags;
   logic [COL_W-1:0] push_col;
   logic             queue_full;
   logic             queue_not_empty;
   cell_flags_type   head_flags;
   logic [COL_W-1:0] head_col;
   logic             pop;

   msq_front #(
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cell_bit  (req_cell_bit),
      .req_last_cell (req_last_cell),
      .queue_full    (queue_full),
      .push          (push),
      .push_flags    (push_flags),
      .push_col      (push_col)
   );

   msq_queue #(
      .COL_W (COL_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_flags (push_flags),
      .push_col   (push_col),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head_flags (head_flags),
      .head_col   (head_col)
   );

   msq_back #(
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (queue_not_empty),
      .head_flags   (head_flags),
      .head_col     (head_col),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_max_area (rsp_max_area),
      .rsp_max_side (rsp_max_side)
   );

endmodule
